>>> rtl/boca_pkg.sv
// shared types and constants of the bit offset copy aligner
`default_nettype none
package boca_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SRC_BIT_OFFSET = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DST_BIT_OFFSET = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIT_LENGTH     = 2'd2;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned IndexW = 14;
  localparam int unsigned LenW   = 16;

  // input beat
  typedef struct packed {
    logic [7:0] src_byte;
    logic [7:0] old_dst_byte;
    logic       first;
  } boca_in_t;

  // result beat
  typedef struct packed {
    logic [7:0]        dst_byte;
    logic [IndexW-1:0] dst_index;
    logic              last;
  } boca_out_t;

  // work handed from front to back: aligned source bits and merge mask
  typedef struct packed {
    logic [7:0]        window;
    logic [7:0]        mask;
    logic [7:0]        old_dst_byte;
    logic [IndexW-1:0] dst_index;
    logic              last;
  } boca_op_t;

endpackage
`default_nettype wire

>>> rtl/boca_front.sv
// front: config registers, job tracking, source alignment and mask build
`default_nettype none
module boca_front import boca_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                in_accept,
  input  wire boca_in_t            in_data,
  output logic                     op_push,
  output boca_op_t                 op_data
);

  logic [2:0]        src_off_r;
  logic [2:0]        dst_off_r;
  logic [LenW-1:0]   bit_len_r;
  logic [7:0]        held_r;
  logic [LenW-1:0]   bits_left_r, bits_left_nxt;
  logic [IndexW-1:0] count_r, count_nxt;

  logic [LenW-1:0]   bl_eff;
  logic [IndexW-1:0] cnt_eff;
  logic              skip_now;
  logic              emit;
  logic [3:0]        shift;
  logic [15:0]       pair;
  logic [2:0]        start;
  logic [3:0]        room;
  logic [3:0]        nbits;
  logic [3:0]        stop;
  logic [7:0]        mask;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_off_r <= '0;
      dst_off_r <= '0;
      bit_len_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_SRC_BIT_OFFSET: src_off_r <= cfg_data[2:0];
        CFG_DST_BIT_OFFSET: dst_off_r <= cfg_data[2:0];
        CFG_BIT_LENGTH:     bit_len_r <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // job state as seen by this beat
  assign bl_eff   = in_data.first ? bit_len_r : bits_left_r;
  assign cnt_eff  = in_data.first ? '0 : count_r;
  assign skip_now = in_data.first && (dst_off_r < src_off_r);
  assign emit     = !skip_now && (bl_eff != '0);

  // align source: previous byte low, current byte high
  assign shift = (dst_off_r >= src_off_r) ? (4'd8 - {1'b0, dst_off_r - src_off_r})
                                          : {1'b0, src_off_r - dst_off_r};
  assign pair  = {in_data.src_byte, held_r} >> shift;

  // bits written into this destination byte
  assign start = (cnt_eff == '0) ? dst_off_r : 3'd0;
  assign room  = 4'd8 - {1'b0, start};
  assign nbits = (bl_eff < {{(LenW-4){1'b0}}, room}) ? bl_eff[3:0] : room;
  assign stop  = {1'b0, start} + nbits;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i] = (4'(i) >= {1'b0, start}) && (4'(i) < stop);
    end
  end

  // next job state
  always_comb begin
    bits_left_nxt = bl_eff;
    count_nxt     = cnt_eff;
    if (emit) begin
      bits_left_nxt = bl_eff - {{(LenW-4){1'b0}}, nbits};
      count_nxt     = cnt_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      bits_left_r <= '0;
      count_r     <= '0;
    end else if (in_accept) begin
      held_r      <= in_data.src_byte;
      bits_left_r <= bits_left_nxt;
      count_r     <= count_nxt;
    end
  end

  // hand the beat to the back
  assign op_push              = in_accept && emit;
  assign op_data.window       = pair[7:0];
  assign op_data.mask         = mask;
  assign op_data.old_dst_byte = in_data.old_dst_byte;
  assign op_data.dst_index    = cnt_eff;
  assign op_data.last         = (bits_left_nxt == '0);

endmodule
`default_nettype wire

>>> rtl/boca_queue.sv
// two-entry queue of merge work between front and back
`default_nettype none
module boca_queue import boca_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire boca_op_t push_data,
  input  wire logic     pop,
  output boca_op_t      pop_data,
  output logic          full,
  output logic          empty
);

  boca_op_t   mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("push did not grow queue");

endmodule
`default_nettype wire

>>> rtl/boca_back.sv
// back: merge aligned bits into the old destination byte, result register
`default_nettype none
module boca_back import boca_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_empty,
  input  wire boca_op_t q_data,
  output logic          q_pop,
  input  wire logic     out_pop,
  output logic          out_empty,
  output boca_out_t     out_data
);

  logic      valid_r;
  boca_out_t res_r;
  boca_out_t res_nxt;

  // refill when the register is free or being drained this cycle
  assign q_pop = !q_empty && (!valid_r || out_pop);

  assign res_nxt.dst_byte  = (q_data.old_dst_byte & ~q_data.mask) |
                             (q_data.window & q_data.mask);
  assign res_nxt.dst_index = q_data.dst_index;
  assign res_nxt.last      = q_data.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_empty = !valid_r;
  assign out_data  = res_r;

endmodule
`default_nettype wire

>>> rtl/bit_offset_copy_aligner_top.sv
// top level of the bit offset copy aligner
//
//   port group   direction  handshake             beat
//   in_*         in         in_push / in_full     boca_in_t (source, old dest, first)
//   out_*        out        out_pop / out_empty   boca_out_t (dest byte, index, last)
//   cfg_*        in         cfg_valid / cfg_ready index 0..2, 16-bit data
//
// one input beat per clock while in_full stays low; the front writes the queue at the
// accept edge, and the back loads the result register from the queue when the register
// is free or being popped, after which the result shows on out_* and can be popped.
// the front holds all job state and updates it on every accepted beat, so it sets the rate.
// reset (rst_n low, synchronous) empties queue and result register, clears
// registers and job state; no clearing pass. cfg_ready is always high.
// a stalled out_pop fills the two-entry queue, then in_full rises.
`default_nettype none
module bit_offset_copy_aligner_top import boca_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire boca_in_t            in_data,
  output logic                     in_full,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output boca_out_t                out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic     in_accept;
  logic     op_push;
  boca_op_t op_data;
  logic     q_pop;
  logic     q_empty;
  boca_op_t q_data;

  assign cfg_ready = 1'b1;
  assign in_accept = in_push && !in_full;

  boca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_data   (in_data),
    .op_push   (op_push),
    .op_data   (op_data)
  );

  boca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .push_data (op_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (in_full),
    .empty     (q_empty)
  );

  boca_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> bench/boca_sb_pkg.sv
// scoreboard class for the bit offset copy aligner bench: bit-level predictor and result queue
package boca_sb_pkg;
  import boca_pkg::*;

  class copy_merge_scoreboard;
    // merged destination bytes still owed by the block, oldest first
    boca_out_t   expected_bytes[$];

    // shadow of the configuration registers
    logic [2:0]  src_off;
    logic [2:0]  dst_off;
    logic [15:0] bit_len;

    // shadow of the job state
    logic [7:0]  held_src;
    int unsigned bits_left;
    int unsigned out_count;
    bit          skip_first;

    int unsigned mismatches;
    int unsigned beats_seen;
    int unsigned bytes_checked;
    int unsigned cfg_writes;

    function new();
      clear_state();
    endfunction

    // state after reset
    function void clear_state();
      src_off    = '0;
      dst_off    = '0;
      bit_len    = '0;
      held_src   = '0;
      bits_left  = 0;
      out_count  = 0;
      skip_first = 1'b0;
      expected_bytes.delete();
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // register write beat; unknown indexes are dropped
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      cfg_writes++;
      case (idx)
        CFG_SRC_BIT_OFFSET: src_off = data[2:0];
        CFG_DST_BIT_OFFSET: dst_off = data[2:0];
        CFG_BIT_LENGTH:     bit_len = data[LenW-1:0];
        default: ;
      endcase
    endfunction

    // advance the job state by one source beat and queue the byte it yields, if any
    function void note_input(boca_in_t beat);
      int unsigned s;
      int unsigned d;
      int unsigned window;
      int unsigned shift;
      int unsigned start;
      int unsigned room;
      int unsigned take;
      int unsigned mask;
      boca_out_t   res;
      beats_seen++;
      s = src_off;
      d = dst_off;
      // job start: reload length, maybe hold back the first beat
      if (beat.first) begin
        bits_left  = bit_len;
        out_count  = 0;
        skip_first = (d < s);
        if (skip_first || bits_left == 0) begin
          held_src = beat.src_byte;
          return;
        end
      end
      skip_first = 1'b0;
      // no job running
      if (bits_left == 0) begin
        held_src = beat.src_byte;
        return;
      end
      // previous byte low, current byte high, shifted into destination alignment
      window = ({24'd0, beat.src_byte} << 8) | {24'd0, held_src};
      shift  = (d >= s) ? 8 - (d - s) : s - d;
      window = (window >> shift) & 32'hFF;
      // bits that this destination byte takes
      start = (out_count == 0) ? d : 0;
      room  = 8 - start;
      take  = (bits_left < room) ? bits_left : room;
      mask  = (((32'd1 << take) - 1) << start) & 32'hFF;
      res.dst_byte  = 8'(({24'd0, beat.old_dst_byte} & ~mask) | (window & mask));
      bits_left     = bits_left - take;
      res.dst_index = IndexW'(out_count);
      res.last      = (bits_left == 0);
      expected_bytes.push_back(res);
      out_count = (out_count + 1) & 32'h3FFF;
      held_src  = beat.src_byte;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 100)
        $display("[%0t] mismatch after %0d bytes: %s", $time, bytes_checked, what);
    endtask

    // compare one popped result beat with the oldest owed byte
    task check_result(boca_out_t got);
      boca_out_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("result with nothing owed: byte %02h index %0d last %0b",
                         got.dst_byte, got.dst_index, got.last));
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.dst_byte !== want.dst_byte)
        report($sformatf("dst_byte %02h, want %02h", got.dst_byte, want.dst_byte));
      if (got.dst_index !== want.dst_index)
        report($sformatf("dst_index %0d, want %0d", got.dst_index, want.dst_index));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

endpackage

>>> bench/bit_offset_copy_aligner_top_tb.sv
// testbench top: directed and random copy jobs with random idling, checked by the scoreboard
module bit_offset_copy_aligner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import boca_pkg::*;
  import boca_sb_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned DRAIN_SLACK  = 6;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned RANDOM_BEATS = 500;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_push   = 1'b0;
  boca_in_t            in_data   = '0;
  logic                in_full;
  logic                out_empty;
  logic                out_pop   = 1'b0;
  boca_out_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  copy_merge_scoreboard sb = new();

  // stimulus-side copy of the settings, used to size jobs
  int unsigned cur_src = 0;
  int unsigned cur_dst = 0;
  int unsigned cur_len = 0;

  bit          sender_fast = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned holds_done  = 0;
  int unsigned jobs_run    = 0;
  int unsigned job_beats   = 0;
  int unsigned idle_cycles = 0;

  bit_offset_copy_aligner_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // beat monitor: feeds the scoreboard and counts cycles with no progress
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    if (rst_n && in_push && !in_full) sb.note_input(in_data);
    if (rst_n && out_pop && !out_empty) sb.check_result(out_data);
    if ((cfg_valid && cfg_ready) || (in_push && !in_full) || (out_pop && !out_empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic boca_in_t mk_beat(logic [7:0] src, logic [7:0] old, logic first);
    boca_in_t beat;
    beat.src_byte     = src;
    beat.old_dst_byte = old;
    beat.first        = first;
    return beat;
  endfunction

  // offer one source beat, hold it until taken
  task automatic push_beat(boca_in_t beat);
    int unsigned gap;
    gap = sender_fast ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // stop offering, let every owed byte come out, then let the pipe settle
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SRC_BIT_OFFSET: cur_src = data[2:0];
      CFG_DST_BIT_OFFSET: cur_dst = data[2:0];
      CFG_BIT_LENGTH:     cur_len = data;
      default: ;
    endcase
  endtask

  // offsets carry random junk above bit 2
  task automatic apply_config(int unsigned s, int unsigned d, int unsigned len);
    cfg_write(CFG_SRC_BIT_OFFSET, (16'($urandom) & 16'hFFF8) | 16'(s));
    cfg_write(CFG_DST_BIT_OFFSET, (16'($urandom) & 16'hFFF8) | 16'(d));
    cfg_write(CFG_BIT_LENGTH, 16'(len));
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 60) return $urandom_range(1, 24);
    if (r < 90) return $urandom_range(25, 120);
    return $urandom_range(121, 400);
  endfunction

  // one copy job from the current settings; may be cut short by the next job,
  // may have a register changed partway, may trail surplus beats
  task automatic run_job(bit split, bit cut, int unsigned extra);
    int unsigned n;
    int unsigned split_at;
    int unsigned i;
    n = (cur_len == 0) ? 0 : (cur_dst + cur_len + 7) / 8;
    if (cur_len != 0 && cur_dst < cur_src) n++;
    if (n == 0) n = 1;
    if (cut && n > 1) n = $urandom_range(1, n - 1);
    split_at = split ? $urandom_range(1, n) : 0;
    for (i = 0; i < n; i++) begin
      // live register change while the job is open
      if (split && i == split_at) begin
        wait_idle();
        case ($urandom_range(0, 2))
          0: cfg_write(CFG_SRC_BIT_OFFSET, 16'($urandom));
          1: cfg_write(CFG_DST_BIT_OFFSET, 16'($urandom));
          default: cfg_write(CFG_BIT_LENGTH, 16'(pick_len()));
        endcase
      end
      push_beat(mk_beat(8'($urandom), 8'($urandom), i == 0));
      job_beats++;
    end
    repeat (extra) push_beat(mk_beat(8'($urandom), 8'($urandom), 1'b0));
    jobs_run++;
  endtask

  // receiver: random pops, with a long hold-off when asked
  initial begin : pop_side
    int unsigned stall;
    int unsigned run;
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        stall = pick_gap();
        run   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
        if (stall > 0) begin
          out_pop <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_pop <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  // no progress for too long
  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[%0t] no beat moved for %0d cycles", $time, IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned s;
    int unsigned d;
    int unsigned njobs;
    int unsigned j;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // beats before any job yield nothing
    push_beat(mk_beat(8'hFF, 8'hFF, 1'b0));
    push_beat(mk_beat(8'h00, 8'h00, 1'b0));
    wait_idle();

    // aligned full byte, then a surplus beat
    apply_config(0, 0, 8);
    push_beat(mk_beat(8'hFF, 8'h00, 1'b1));
    push_beat(mk_beat(8'h00, 8'hFF, 1'b0));
    wait_idle();

    // dst offset below src offset: first beat held back
    apply_config(7, 0, 9);
    push_beat(mk_beat(8'h80, 8'hA5, 1'b1));
    push_beat(mk_beat(8'h01, 8'h00, 1'b0));
    push_beat(mk_beat(8'h00, 8'hFF, 1'b0));
    wait_idle();

    // single bit into the top of the byte
    apply_config(0, 7, 1);
    push_beat(mk_beat(8'h01, 8'h00, 1'b1));
    push_beat(mk_beat(8'hFE, 8'hFF, 1'b1));
    wait_idle();

    // restart mid job, then a zero length job and a beat with no job
    apply_config(3, 5, 20);
    push_beat(mk_beat(8'($urandom), 8'($urandom), 1'b1));
    push_beat(mk_beat(8'($urandom), 8'($urandom), 1'b0));
    push_beat(mk_beat(8'($urandom), 8'($urandom), 1'b1));
    wait_idle();
    apply_config(3, 5, 0);
    push_beat(mk_beat(8'hFF, 8'hFF, 1'b1));
    push_beat(mk_beat(8'h00, 8'h00, 1'b0));
    wait_idle();

    // unused register index changes nothing
    cfg_write(CFG_UNUSED_IDX, 16'hFFFF);
    apply_config(7, 7, 16);
    run_job(1'b0, 1'b0, 0);
    wait_idle();

    // random phases
    phase = 0;
    while (job_beats < RANDOM_BEATS) begin
      wait_idle();
      s = $urandom_range(0, 7);
      d = $urandom_range(0, 7);
      if ($urandom_range(0, 99) < 15) begin
        s = $urandom_range(0, 1) * 7;
        d = $urandom_range(0, 1) * 7;
      end
      if ($urandom_range(0, 19) == 0) cfg_write(CFG_UNUSED_IDX, 16'($urandom));
      sender_fast = ($urandom_range(0, 3) == 0);
      if (phase % 6 == 2) begin
        // receiver stalls while the sender keeps offering: input backs up
        apply_config(s, d, $urandom_range(200, 400));
        sender_fast = 1'b1;
        hold_req    = 1'b1;
        run_job(1'b0, 1'b0, 0);
      end else begin
        apply_config(s, d, pick_len());
        njobs = $urandom_range(1, 4);
        for (j = 0; j < njobs; j++)
          run_job($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end
      phase++;
    end
    wait_idle();

    // full-length job, only its first four beats sent before it is dropped
    sender_fast = 1'b0;
    apply_config(0, 7, 65535);
    for (j = 0; j < 4; j++) begin
      push_beat(mk_beat(8'($urandom), 8'($urandom), j == 0));
      job_beats++;
    end
    jobs_run++;
    wait_idle();

    if (sb.pending() != 0)
      sb.report($sformatf("%0d bytes never came out", sb.pending()));
    $display("covered %0d jobs, %0d job beats, %0d source beats, %0d bytes checked",
             jobs_run, job_beats, sb.beats_seen, sb.bytes_checked);
    $display("covered %0d register writes and %0d receiver hold-offs, %0d mismatches",
             sb.cfg_writes, holds_done, sb.mismatches);
    if (sb.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
rtl/boca_pkg.sv
rtl/boca_front.sv
rtl/boca_queue.sv
rtl/boca_back.sv
rtl/bit_offset_copy_aligner_top.sv
bench/boca_sb_pkg.sv
bench/bit_offset_copy_aligner_top_tb.sv
